// ===== sv/assert_macros.svh =====
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every rising clock edge outside reset.
`define ASSERT_IMP(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== sv/clwa_pkg.sv =====
// Package with types and constants of the load average unit.
`timescale 1ns / 1ps
`default_nettype none
package clwa_pkg;
  localparam int unsigned CntW = 64;
  localparam int unsigned FreqW = 22;
  localparam int unsigned LoadW = 7;
  localparam int unsigned WinW = 32;
  localparam logic [FreqW-1:0] MaxFreqReset = 22'd1500000;
  localparam logic [LoadW-1:0] PctFull = 7'd100;
  localparam int unsigned QueueDepth = 2;

  typedef enum logic [1:0] {
    REQ_FREQ = 2'd0,
    REQ_REPORT = 2'd1,
    REQ_ONLINE = 2'd2,
    REQ_FROZEN = 2'd3
  } req_e;

  typedef struct packed {
    req_e req;
    logic [CntW-1:0] wall;
    logic [CntW-1:0] idle;
    logic [CntW-1:0] iowait;
    logic [FreqW-1:0] freq;
  } item_t;
endpackage
`default_nettype wire

// ===== sv/cpu_load_weighted_average_unit.sv =====
// Top level of the per-core load average unit.
// From input transaction to result valid: a folding event that averages runs three
// passes of the serial divider (busy fraction, frequency scaling, average), one that
// restarts the average skips the last pass, and online, frozen and skipped events use none.
// One event at a time; the next is popped from the queue only after the result is
// taken, while a two-entry queue keeps taking input. Reset: asynchronous active low;
// counters, average, window, frequency clear, max frequency returns to 1500000 kHz.
`timescale 1ns / 1ps
`default_nettype none
module cpu_load_weighted_average_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata: wall_us[63:0], idle_us[127:64], iowait_us[191:128], new_freq_khz[213:192]
  input  logic [215:0] s_axis_tdata,
  // tuser: req_type[1:0]
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata: avg_load[6:0], window_us[38:7]
  output logic [39:0]  m_axis_tdata,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [21:0]  cfg_data_i
);
  import clwa_pkg::*;
  `include "assert_macros.svh"

  logic [FreqW-1:0] fmax_q;
  item_t in_item, q_item;
  logic q_valid, q_pop;
  logic [LoadW-1:0] avg_load;
  logic [WinW-1:0] window;

  // config register, always writable
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) fmax_q <= MaxFreqReset;
    else if (cfg_valid_i) fmax_q <= cfg_data_i;
  end

  assign in_item.req = req_e'(s_axis_tuser);
  assign in_item.wall = s_axis_tdata[63:0];
  assign in_item.idle = s_axis_tdata[127:64];
  assign in_item.iowait = s_axis_tdata[191:128];
  assign in_item.freq = s_axis_tdata[213:192];

  clwa_front u_front (
    .clk_i, .rst_ni, .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .in_item_i(in_item), .q_valid_o(q_valid), .q_pop_i(q_pop), .q_item_o(q_item)
  );

  clwa_back u_back (
    .clk_i, .rst_ni, .fmax_i(fmax_q), .q_valid_i(q_valid), .q_pop_o(q_pop),
    .q_item_i(q_item), .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .avg_load_o(avg_load), .window_o(window)
  );

  assign m_axis_tdata = {1'b0, window, avg_load};

  `ASSERT_IMP(a_load_range, clk_i, rst_ni, m_axis_tvalid, avg_load <= PctFull)
  `ASSERT_NXT(a_out_holds, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready,
              m_axis_tvalid && $stable(m_axis_tdata))
  `ASSERT_IMP(a_pop_valid, clk_i, rst_ni, q_pop, q_valid)
endmodule
`default_nettype wire

// ===== sv/clwa_divider.sv =====
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module clwa_divider #(
  parameter int unsigned NumW = 64,
  parameter int unsigned DenW = 33
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic            done_o,
  output logic [NumW-1:0] quot_o
);
  localparam int unsigned CntW = $clog2(NumW + 1);
  logic [NumW-1:0] quot_q, quot_d;
  logic [DenW:0] rem_q, rem_d;
  logic [DenW-1:0] den_q, den_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic busy_q, busy_d, done_q, done_d;
  logic [DenW:0] trial;

  always_comb begin
    quot_d = quot_q;
    rem_d = rem_q;
    den_d = den_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial = {rem_q[DenW-1:0], quot_q[NumW-1]};
    if (start_i) begin
      quot_d = num_i;
      rem_d = '0;
      den_d = den_i;
      cnt_d = CntW'(NumW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quot_d = {quot_q[NumW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quot_d = {quot_q[NumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
endmodule
`default_nettype wire

// ===== sv/clwa_front.sv =====
// Front end: a short item queue.
`timescale 1ns / 1ps
`default_nettype none
module clwa_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  clwa_pkg::item_t    in_item_i,
  output logic               q_valid_o,
  input  logic               q_pop_i,
  output clwa_pkg::item_t    q_item_o
);
  import clwa_pkg::*;
  item_t mem_q [QueueDepth];
  logic wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic push, pop;

  assign in_ready_o = (cnt_q != 2'(QueueDepth));
  assign q_valid_o = (cnt_q != 2'd0);
  assign push = in_valid_i && in_ready_o;
  assign pop = q_pop_i && q_valid_o;
  assign q_item_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop) rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= in_item_i;
  end
endmodule
`default_nettype wire

// ===== sv/clwa_back.sv =====
// Back end: interval fold sequencer over a shared divider.
`timescale 1ns / 1ps
`default_nettype none
module clwa_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [clwa_pkg::FreqW-1:0]   fmax_i,
  input  logic                         q_valid_i,
  output logic                         q_pop_o,
  input  clwa_pkg::item_t              q_item_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [clwa_pkg::LoadW-1:0]   avg_load_o,
  output logic [clwa_pkg::WinW-1:0]    window_o
);
  import clwa_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_DELTA = 8'b00000010,
    S_BUSY  = 8'b00000100,
    S_MULF  = 8'b00001000,
    S_SCAL  = 8'b00010000,
    S_MULW  = 8'b00100000,
    S_AVG   = 8'b01000000,
    S_OUT   = 8'b10000000
  } state_e;

  state_e state_q, state_d;
  logic [CntW-1:0] pw_q, pi_q, pio_q;
  logic [LoadW-1:0] avg_q;
  logic [WinW-1:0] win_q;
  logic [FreqW-1:0] cur_q;
  item_t it_q;
  logic [WinW-1:0] dw_q;
  logic [LoadW-1:0] scaled_q;
  logic [63:0] prod_q;
  logic [32:0] den_q;
  logic [LoadW-1:0] res_avg_q;
  logic [WinW-1:0] res_win_q;
  logic out_valid_q;

  logic div_start, div_done;
  logic [63:0] div_num, div_quot;
  logic [32:0] div_den;

  logic [WinW-1:0] dw, di, dio, di_adj;
  logic [32:0] wsum;

  clwa_divider #(.NumW(64), .DenW(33)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(div_den),
    .done_o(div_done), .quot_o(div_quot)
  );

  assign dw = WinW'(it_q.wall - pw_q);
  assign di = WinW'(it_q.idle - pi_q);
  assign dio = WinW'(it_q.iowait - pio_q);
  assign di_adj = (di >= dio) ? di - dio : di;
  assign wsum = {1'b0, win_q} + {1'b0, dw_q};

  always_comb begin
    state_d = state_q;
    div_start = 1'b0;
    div_num = prod_q;
    div_den = den_q;
    q_pop_o = 1'b0;
    unique case (state_q)
      S_IDLE: if (q_valid_i && !out_valid_q) begin
        q_pop_o = 1'b1;
        state_d = S_DELTA;
      end
      S_DELTA: begin
        if (it_q.req == REQ_FREQ || it_q.req == REQ_REPORT) begin
          if (dw == '0 || dw < di_adj) state_d = S_OUT;
          else begin
            div_start = 1'b1;
            div_num = 64'(dw - di_adj) * 64'(PctFull);
            div_den = {1'b0, dw};
            state_d = S_BUSY;
          end
        end else state_d = S_OUT;
      end
      S_BUSY: if (div_done) state_d = S_MULF;
      S_MULF: begin
        div_start = 1'b1;
        div_num = 64'(div_quot[LoadW-1:0]) * 64'(cur_q);
        div_den = 33'((fmax_i == '0) ? FreqW'(1) : fmax_i);
        state_d = S_SCAL;
      end
      S_SCAL: if (div_done) state_d = S_MULW;
      S_MULW: begin
        if (avg_q == '0) state_d = S_OUT;
        else begin
          div_start = 1'b1;
          div_num = 64'(avg_q) * 64'(win_q) + 64'(scaled_q) * 64'(dw_q);
          div_den = wsum;
          state_d = S_AVG;
        end
      end
      S_AVG: if (div_done) state_d = S_OUT;
      S_OUT: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pw_q <= '0; pi_q <= '0; pio_q <= '0;
      avg_q <= '0; win_q <= '0; cur_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      if (state_q == S_DELTA && (it_q.req == REQ_FREQ || it_q.req == REQ_REPORT)) begin
        pw_q <= it_q.wall; pi_q <= it_q.idle; pio_q <= it_q.iowait;
      end
      if (state_q == S_MULW && avg_q == '0) begin
        avg_q <= scaled_q;
        win_q <= dw_q;
      end
      if (state_q == S_AVG && div_done) begin
        avg_q <= (div_quot > 64'(PctFull)) ? PctFull : div_quot[LoadW-1:0];
        win_q <= wsum[32] ? '1 : wsum[WinW-1:0];
      end
      if (state_q == S_OUT) begin
        out_valid_q <= 1'b1;
        unique case (it_q.req)
          REQ_FREQ: cur_q <= it_q.freq;
          REQ_REPORT: avg_q <= '0;
          REQ_ONLINE: begin
            if (cur_q == '0) cur_q <= it_q.freq;
            avg_q <= '0;
          end
          default: avg_q <= '0;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) it_q <= q_item_i;
    if (state_q == S_DELTA) dw_q <= dw;
    if (state_q == S_BUSY && div_done) prod_q <= div_quot;
    if (state_q == S_MULF) den_q <= div_den;
    if (state_q == S_SCAL && div_done)
      scaled_q <= (div_quot > 64'(PctFull)) ? PctFull : div_quot[LoadW-1:0];
    if (state_q == S_OUT) begin
      res_avg_q <= avg_q;
      res_win_q <= win_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign avg_load_o = res_avg_q;
  assign window_o = res_win_q;
endmodule
`default_nettype wire

// ===== verif/clwa_checker.sv =====
// Checker for the load average unit: predicts each result and compares it.
`timescale 1ns / 1ps
`default_nettype none
module clwa_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [215:0] s_axis_tdata,
  input  logic [1:0]  s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [39:0] m_axis_tdata,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_o,
  input  logic [21:0] cfg_data_i,
  output int unsigned errors_o,
  output int unsigned pending_o
);
  import clwa_pkg::*;

  typedef struct packed {
    logic [LoadW-1:0] load;
    logic [WinW-1:0]  win;
  } load_rec_t;

  logic [FreqW-1:0] fmax_khz;
  logic [CntW-1:0]  last_wall, last_idle, last_iowait;
  logic [LoadW-1:0] avg_load;
  logic [WinW-1:0]  win_time;
  logic [FreqW-1:0] freq_now;
  load_rec_t        load_q[$];

  task automatic report(input string what, input longint unsigned got,
                        input longint unsigned want);
    $display("%0t mismatch %s: got %0d, want %0d", $time, what, got, want);
    errors_o++;
  endtask

  // Fold the interval since the last folding event into the weighted average.
  function automatic void fold_interval(input logic [CntW-1:0] wall,
                                        input logic [CntW-1:0] idle,
                                        input logic [CntW-1:0] iowait);
    logic [31:0] dw, di, dio;
    logic [63:0] busy, scaled, maxf, num, den;
    dw  = 32'(wall - last_wall);
    di  = 32'(idle - last_idle);
    dio = 32'(iowait - last_iowait);
    last_wall   = wall;
    last_idle   = idle;
    last_iowait = iowait;
    if (di >= dio) di -= dio;
    if (dw == 0 || dw < di) return;
    busy   = (64'd100 * 64'(dw - di)) / 64'(dw);
    maxf   = (fmax_khz == 0) ? 64'd1 : 64'(fmax_khz);
    scaled = (busy * 64'(freq_now)) / maxf;
    if (scaled > 100) scaled = 100;
    if (avg_load == 0) begin
      avg_load = LoadW'(scaled);
      win_time = dw;
    end else begin
      num = 64'(avg_load) * 64'(win_time) + scaled * 64'(dw);
      den = 64'(win_time) + 64'(dw);
      num = num / den;
      avg_load = (num > 100) ? PctFull : LoadW'(num);
      win_time = (den > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(den);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    load_rec_t got, want;
    req_e      req;
    if (!rst_ni) begin
      fmax_khz = MaxFreqReset;
      last_wall = '0; last_idle = '0; last_iowait = '0;
      avg_load = '0; win_time = '0; freq_now = '0;
      load_q.delete();
      errors_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) fmax_khz = cfg_data_i;
      if (s_axis_tvalid && s_axis_tready) begin
        req = req_e'(s_axis_tuser);
        if (req == REQ_FREQ || req == REQ_REPORT)
          fold_interval(s_axis_tdata[63:0], s_axis_tdata[127:64], s_axis_tdata[191:128]);
        load_q.push_back('{load: avg_load, win: win_time});
        case (req)
          REQ_FREQ:   freq_now = s_axis_tdata[213:192];
          REQ_ONLINE: begin
            if (freq_now == 0) freq_now = s_axis_tdata[213:192];
            avg_load = '0;
          end
          default:    avg_load = '0;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = '{load: m_axis_tdata[6:0], win: m_axis_tdata[38:7]};
        if (load_q.size() == 0) begin
          report("unexpected transaction", 64'(got), 64'd0);
        end else begin
          want = load_q.pop_front();
          if (got.load !== want.load) report("avg_load", 64'(got.load), 64'(want.load));
          if (got.win !== want.win) report("window_us", 64'(got.win), 64'(want.win));
        end
      end
    end
    pending_o = load_q.size();
  end
endmodule
`default_nettype wire

// ===== verif/cpu_load_weighted_average_unit_tb.sv =====
// Testbench top: drives events and config writes, gives the verdict.
`timescale 1ns / 1ps
`default_nettype none
module cpu_load_weighted_average_unit_tb;
  import clwa_pkg::*;

  localparam int unsigned CycleLimit = 1_500_000;
  localparam int unsigned HoldCycles = 400;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [215:0] s_axis_tdata = '0;
  logic [1:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [39:0]  m_axis_tdata;
  logic         cfg_valid_i = 1'b0;
  logic         cfg_ready_o;
  logic [21:0]  cfg_data_i = '0;
  int unsigned  errors, pending;
  int unsigned  cycles = 0;

  // Stimulus-side view of the cumulative counters.
  logic [CntW-1:0] wall_now = '0, idle_now = '0, iowait_now = '0;
  bit quiet = 1'b0;     // no idling on either side while set
  bit hold_req = 1'b0;  // asks the receiver for a long hold-off

  // Max frequency of each random phase.
  logic [FreqW-1:0] phase_freq[5] = '{22'd1, 22'd4000000, 22'd0, 22'd2000000, 22'd1500000};

  cpu_load_weighted_average_unit dut (.*);

  clwa_checker u_checker (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .cfg_valid_i, .cfg_ready_o,
    .cfg_data_i, .errors_o(errors), .pending_o(pending)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Run limit.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("cpu_load_weighted_average_unit_tb: done, errors");
      $finish;
    end
  end

  // Receiver: random stalls, or a long hold-off on request.
  always @(posedge clk_i) begin
    if (hold_req) begin
      m_axis_tready <= 1'b0;
      repeat (HoldCycles) @(posedge clk_i);
      hold_req = 1'b0;
    end else begin
      m_axis_tready <= quiet || ($urandom_range(99) >= 17);
    end
  end

  // One transaction on the event channel; tvalid stays high on return.
  task automatic send_event(input req_e req, input logic [CntW-1:0] wall,
                            input logic [CntW-1:0] idle, input logic [CntW-1:0] iowait,
                            input logic [FreqW-1:0] freq);
    if (!quiet && $urandom_range(99) < 17) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req;
    s_axis_tdata  <= {2'b00, freq, iowait, idle, wall};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Advance the counters by the given deltas and send the event.
  task automatic send_step(input req_e req, input logic [31:0] dw,
                           input logic [31:0] di, input logic [31:0] dio,
                           input logic [FreqW-1:0] freq);
    wall_now   += dw;
    idle_now   += di;
    iowait_now += dio;
    send_event(req, wall_now, idle_now, iowait_now, freq);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Register write only with the block idle.
  task automatic write_fmax(input logic [FreqW-1:0] value);
    drain();
    repeat (10) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // Mostly well-formed events; some noise with arbitrary counters.
  task automatic random_event();
    logic [31:0] dw, di, dio;
    req_e req;
    int unsigned pick;
    pick = $urandom_range(99);
    req = (pick < 45) ? REQ_FREQ : (pick < 85) ? REQ_REPORT :
          (pick < 93) ? REQ_ONLINE : REQ_FROZEN;
    if ($urandom_range(99) < 8) begin
      wall_now   = {$urandom, $urandom};
      idle_now   = {$urandom, $urandom};
      iowait_now = {$urandom, $urandom};
      send_event(req, wall_now, idle_now, iowait_now, FreqW'($urandom));
      return;
    end
    dw  = ($urandom_range(19) == 0) ? $urandom : $urandom_range(200000);
    di  = ($urandom_range(19) == 0) ? $urandom : $urandom_range(dw);
    dio = ($urandom_range(9) == 0) ? $urandom : $urandom_range(di / 4 + 1);
    send_step(req, dw, di, dio, FreqW'($urandom_range(4000000)));
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part at the reset value of max frequency.
    send_step(REQ_ONLINE, 0, 0, 0, 22'd4000000);       // online takes freq when zero
    send_step(REQ_ONLINE, 0, 0, 0, 22'd1000);          // freq already set, kept
    send_step(REQ_REPORT, 1000, 250, 50, 0);            // first sample of a window
    send_step(REQ_FREQ, 1000, 0, 0, 22'd3000000);       // full load, saturates
    send_step(REQ_FREQ, 0, 0, 0, 22'd1500000);          // empty interval
    send_step(REQ_FREQ, 100, 300, 0, 22'd1500000);      // wall below idle
    send_step(REQ_REPORT, 100, 50, 80, 0);              // iowait above idle
    send_step(REQ_FROZEN, 0, 0, 0, 0);
    send_step(REQ_FREQ, 32'hFFFF_FFF0, 32'h1000_0000, 0, 22'd1500000);
    send_step(REQ_FREQ, 32'hFFFF_FF00, 32'h2000_0000, 0, 22'd1500000); // window saturates
    send_step(REQ_REPORT, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF, 0);
    send_event(REQ_FREQ, '1, '1, '1, 22'd4000000);      // all-ones counters, wrapping deltas
    send_event(REQ_REPORT, '0, '0, '0, 0);
    wall_now = '0; idle_now = '0; iowait_now = '0;
    send_step(REQ_FREQ, 5000, 1000, 100, 22'd4000000);
    send_step(REQ_REPORT, 5000, 1000, 100, 0);

    // Random phases, each with its own max frequency.
    foreach (phase_freq[p]) begin
      write_fmax(phase_freq[p]);
      for (int i = 0; i < 240; i++) begin
        quiet = (p == 1 && i >= 40 && i < 120);
        if (p == 2 && i == 60) begin
          hold_req = 1'b1;            // receiver stops; block fills and stalls input
        end
        if (p == 3 && i == 100) drain();  // sender waits out every result
        random_event();
      end
      quiet = 1'b0;
    end

    drain();
    repeat (150) @(posedge clk_i);
    if (errors == 0) begin
      $display("cpu_load_weighted_average_unit_tb: done, clean");
    end else begin
      $display("cpu_load_weighted_average_unit_tb: done, errors");
    end
    $finish;
  end
endmodule
`default_nettype wire
